// ----- rtl/pdga_pkg.sv -----
// Shared types and codes for the Poisson-disc grid acceptance block.
package pdga_pkg;

  // Quotient width of the cell index divider (whole-unit coordinate width).
  localparam int QW = 12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_AREA_W    = 2'd0;
  localparam logic [1:0] CFG_AREA_H    = 2'd1;
  localparam logic [1:0] CFG_MIN_RAD   = 2'd2;
  localparam logic [1:0] CFG_CELL_SIZE = 2'd3;

  // Operation codes. Bit 1 selects clear, so both upper codes clear the grid.
  localparam logic [1:0] OP_TEST      = 2'd0;
  localparam logic [1:0] OP_SEED      = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALT = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_OUTSIDE   = 3'd1;
  localparam logic [2:0] ST_TOO_CLOSE = 3'd2;
  localparam logic [2:0] ST_SEED      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;
  localparam logic [2:0] ST_BEYOND    = 3'd5;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic       accepted;
    logic [2:0] status;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
  } out_t;

  // One grid cell as held in memory.
  typedef struct packed {
    logic        valid;
    logic [15:0] x;
    logic [15:0] y;
  } cell_t;

endpackage

// ----- rtl/pdga_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pdga_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/poisson_disc_grid_accept_top.sv -----
// Top level of the Poisson-disc background grid: cell lookup, neighbor check and store.
//
//   Channel   Signals                               Direction
//   input     in_valid_i / in_ready_o / in_data_i    candidate transaction in
//   result    out_valid_o / out_ready_i / out_data_o result transaction out
//   config    cfg_we_i / cfg_idx_i / cfg_wdata_i     register writes, no wait
//
// A test runs the two 12-step cell divisions on the shared restoring divider, the grid
// check and the squared radius, then scans the 25 neighbor cells: a memory read for each
// cell in the grid and, for an occupied one, two squares on the shared multiplier and a
// compare. A test that passes the scan is stored. A seed skips the scan and an
// out-of-area test goes straight to its result. Reset and a clear op each run a clearing
// pass over all GRID_COLS*GRID_ROWS cells of the cell memory, one cell a cycle.
// A finished result waits in the output register; the next transaction is taken
// meanwhile, and the block stalls before loading a result only if one is still held.
module poisson_disc_grid_accept_top #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdga_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdga_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int CW1   = COL_W + 1;
  localparam int RW1   = ROW_W + 1;
  localparam int QW    = pdga_pkg::QW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_CHECK,
    S_R2,
    S_NB_RD,
    S_NB_DX,
    S_NB_DY,
    S_NB_CMP,
    S_STORE,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [11:0]      area_w_q;
  logic [11:0]      area_h_q;
  logic [15:0]      min_rad_q;
  logic [11:0]      cell_size_q;
  logic [1:0]       op_q;
  logic [15:0]      x_q;
  logic [15:0]      y_q;
  logic [QW-1:0]    div_q;
  logic [QW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;
  logic [3:0]       step_q;
  logic [QW-1:0]    col_q;
  logic [QW-1:0]    row_q;
  logic [2:0]       dr_q;
  logic [2:0]       dc_q;
  logic [31:0]      r2_q;
  logic [31:0]      sqx_q;
  logic [31:0]      sqy_q;
  logic [15:0]      ady_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             clr_report_q;
  pdga_pkg::out_t   res_q;
  pdga_pkg::out_t   out_q;
  logic             out_valid_q;

  // Divider step: one quotient bit per cycle.
  logic [QW:0]      div_t;
  logic             div_ge;
  logic [QW:0]      div_sub;
  logic [QW-1:0]    rem_nx;
  logic [QW-1:0]    quo_nx;

  assign div_t   = {rem_q, quo_q[QW-1]};
  assign div_ge  = div_t >= {1'b0, div_q};
  assign div_sub = div_t - {1'b0, div_q};
  assign rem_nx  = div_ge ? div_sub[QW-1:0] : div_t[QW-1:0];
  assign quo_nx  = {quo_q[QW-2:0], div_ge};

  // Neighbor cell address from the 5x5 offsets, with a flag for offsets off the grid.
  logic [CW1-1:0]   nc;
  logic [RW1-1:0]   nr;
  logic             nb_in_grid;
  logic [COL_W-1:0] c_idx;
  logic [ROW_W-1:0] r_idx;
  logic [AW-1:0]    nb_addr;
  logic [CW1-1:0]   nc_off;
  logic [RW1-1:0]   nr_off;

  assign nc         = {1'b0, col_q[COL_W-1:0]} + CW1'(dc_q);
  assign nr         = {1'b0, row_q[ROW_W-1:0]} + RW1'(dr_q);
  assign nb_in_grid = (nc >= CW1'(2)) && (nc < CW1'(GRID_COLS + 2)) &&
                      (nr >= RW1'(2)) && (nr < RW1'(GRID_ROWS + 2));
  assign nc_off     = nc - CW1'(2);
  assign nr_off     = nr - RW1'(2);
  assign c_idx      = nc_off[COL_W-1:0];
  assign r_idx      = nr_off[ROW_W-1:0];
  assign nb_addr    = AW'(r_idx) * AW'(GRID_COLS) + AW'(c_idx);

  // Neighbor scan advance.
  logic             nb_last;
  assign nb_last = (dr_q == 3'd4) && (dc_q == 3'd4);

  // Shared multiplier.
  logic [15:0]      mul_a;
  logic [31:0]      prod;
  pdga_pkg::cell_t  rd_cell;
  logic [15:0]      adx;
  logic [15:0]      ady;

  assign adx = (rd_cell.x > x_q) ? (rd_cell.x - x_q) : (x_q - rd_cell.x);
  assign ady = (rd_cell.y > y_q) ? (rd_cell.y - y_q) : (y_q - rd_cell.y);

  always_comb begin
    case (state_q)
      S_R2:    mul_a = min_rad_q;
      S_NB_DX: mul_a = adx;
      S_NB_DY: mul_a = ady_q;
      default: mul_a = '0;
    endcase
  end

  assign prod = 32'(mul_a) * 32'(mul_a);

  // Squared distance compare.
  logic [32:0]      dist2;
  logic             too_close;
  assign dist2     = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign too_close = dist2 < {1'b0, r2_q};

  // Cell memory ports.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  pdga_pkg::cell_t  ram_wdata;
  logic [$bits(pdga_pkg::cell_t)-1:0] ram_rdata;

  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_STORE);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : nb_addr;
  always_comb begin
    ram_wdata = '0;
    if (state_q == S_STORE) begin
      ram_wdata.valid = 1'b1;
      ram_wdata.x     = x_q;
      ram_wdata.y     = y_q;
    end
  end
  assign rd_cell = pdga_pkg::cell_t'(ram_rdata);

  pdga_ram #(
    .WIDTH ($bits(pdga_pkg::cell_t)),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (nb_addr),
    .rdata_o (ram_rdata)
  );

  // Handshake outputs.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic in_clear;
  logic in_outside;
  assign in_clear   = (in_data_i.opcode == pdga_pkg::OP_CLEAR) ||
                      (in_data_i.opcode == pdga_pkg::OP_CLEAR_ALT);
  assign in_outside = (in_data_i.x_coord[15:4] >= area_w_q) ||
                      (in_data_i.y_coord[15:4] >= area_h_q);

  // A finished result moves to the output register once that register is free.
  logic res_load;
  assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      area_w_q     <= 12'd1024;
      area_h_q     <= 12'd1024;
      min_rad_q    <= 16'd256;
      cell_size_q  <= 12'd11;
      op_q         <= pdga_pkg::OP_TEST;
      x_q          <= '0;
      y_q          <= '0;
      div_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      step_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      dr_q         <= '0;
      dc_q         <= '0;
      r2_q         <= '0;
      sqx_q        <= '0;
      sqy_q        <= '0;
      ady_q        <= '0;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pdga_pkg::CFG_AREA_W:    area_w_q    <= cfg_wdata_i[11:0];
          pdga_pkg::CFG_AREA_H:    area_h_q    <= cfg_wdata_i[11:0];
          pdga_pkg::CFG_MIN_RAD:   min_rad_q   <= cfg_wdata_i;
          pdga_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end

      // The result register loads a finished result or empties when its
      // transaction completes.
      if (res_load) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // Write every cell invalid, one a cycle.
        S_CLEAR: begin
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            clr_cnt_q <= '0;
            if (clr_report_q) begin
              res_q   <= '{accepted: 1'b0, status: pdga_pkg::ST_CLEARED,
                           cell_col: 6'd0, cell_row: 6'd0};
              state_q <= S_DONE;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            op_q   <= in_data_i.opcode;
            x_q    <= in_data_i.x_coord;
            y_q    <= in_data_i.y_coord;
            div_q  <= (cell_size_q == '0) ? QW'(1) : cell_size_q;
            rem_q  <= '0;
            quo_q  <= in_data_i.x_coord[15:4];
            step_q <= '0;
            if (in_clear) begin
              clr_cnt_q    <= '0;
              clr_report_q <= 1'b1;
              state_q      <= S_CLEAR;
            end else if (in_data_i.opcode == pdga_pkg::OP_TEST && in_outside) begin
              res_q   <= '{accepted: 1'b0, status: pdga_pkg::ST_OUTSIDE,
                           cell_col: 6'd0, cell_row: 6'd0};
              state_q <= S_DONE;
            end else begin
              state_q <= S_DIVX;
            end
          end
        end

        // Column = floor(x / 16 / cell_size).
        S_DIVX: begin
          if (step_q == 4'(QW - 1)) begin
            col_q   <= quo_nx;
            rem_q   <= '0;
            quo_q   <= y_q[15:4];
            step_q  <= '0;
            state_q <= S_DIVY;
          end else begin
            rem_q  <= rem_nx;
            quo_q  <= quo_nx;
            step_q <= step_q + 4'd1;
          end
        end

        // Row = floor(y / 16 / cell_size).
        S_DIVY: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          step_q <= step_q + 4'd1;
          if (step_q == 4'(QW - 1)) begin
            row_q   <= quo_nx;
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (col_q >= QW'(GRID_COLS) || row_q >= QW'(GRID_ROWS)) begin
            res_q   <= '{accepted: 1'b0, status: pdga_pkg::ST_BEYOND,
                         cell_col: col_q[5:0], cell_row: row_q[5:0]};
            state_q <= S_DONE;
          end else if (op_q == pdga_pkg::OP_SEED) begin
            dr_q    <= 3'd2;
            dc_q    <= 3'd2;
            state_q <= S_STORE;
          end else begin
            dr_q    <= 3'd0;
            dc_q    <= 3'd0;
            state_q <= S_R2;
          end
        end

        S_R2: begin
          r2_q    <= prod;
          state_q <= S_NB_RD;
        end

        // Issue the read of one neighbor, or skip it if it lies off the grid.
        S_NB_RD: begin
          if (nb_in_grid) begin
            state_q <= S_NB_DX;
          end else if (nb_last) begin
            dr_q    <= 3'd2;
            dc_q    <= 3'd2;
            state_q <= S_STORE;
          end else if (dc_q == 3'd4) begin
            dr_q <= dr_q + 3'd1;
            dc_q <= 3'd0;
          end else begin
            dc_q <= dc_q + 3'd1;
          end
        end

        // Read data is here; empty cells are skipped.
        S_NB_DX: begin
          sqx_q <= prod;
          ady_q <= ady;
          if (rd_cell.valid) begin
            state_q <= S_NB_DY;
          end else if (nb_last) begin
            dr_q    <= 3'd2;
            dc_q    <= 3'd2;
            state_q <= S_STORE;
          end else begin
            state_q <= S_NB_RD;
            if (dc_q == 3'd4) begin
              dr_q <= dr_q + 3'd1;
              dc_q <= 3'd0;
            end else begin
              dc_q <= dc_q + 3'd1;
            end
          end
        end

        S_NB_DY: begin
          sqy_q   <= prod;
          state_q <= S_NB_CMP;
        end

        S_NB_CMP: begin
          if (too_close) begin
            res_q   <= '{accepted: 1'b0, status: pdga_pkg::ST_TOO_CLOSE,
                         cell_col: col_q[5:0], cell_row: row_q[5:0]};
            state_q <= S_DONE;
          end else if (nb_last) begin
            dr_q    <= 3'd2;
            dc_q    <= 3'd2;
            state_q <= S_STORE;
          end else begin
            state_q <= S_NB_RD;
            if (dc_q == 3'd4) begin
              dr_q <= dr_q + 3'd1;
              dc_q <= 3'd0;
            end else begin
              dc_q <= dc_q + 3'd1;
            end
          end
        end

        // The point is written into its own cell in this cycle.
        S_STORE: begin
          res_q   <= '{accepted: 1'b1,
                       status: (op_q == pdga_pkg::OP_TEST) ? pdga_pkg::ST_ACCEPTED
                                                            : pdga_pkg::ST_SEED,
                       cell_col: col_q[5:0], cell_row: row_q[5:0]};
          state_q <= S_DONE;
        end

        // Hand the result over once the output register is free.
        S_DONE: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The cell memory is written only by the clearing pass or a store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_STORE))
    else $error("cell memory written outside clear or store");

  // A new result appears only after the sequencer finished a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised without a finished transaction");

  // Read data is used only in the cycle after its address was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NB_DX) |-> $past(state_q == S_NB_RD) && $stable(nb_addr))
    else $error("neighbor data used without a matching read");

  // Only a stored point reports accepted, with a store status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.accepted) |->
      (out_q.status == pdga_pkg::ST_ACCEPTED || out_q.status == pdga_pkg::ST_SEED))
    else $error("accepted flag with a reject status");

  // A store always targets the candidate's own cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STORE) |-> (dr_q == 3'd2 && dc_q == 3'd2 && nb_in_grid))
    else $error("store aimed at a neighbor cell");

endmodule
